@@ sv/column_strip_sad_matcher_defines.svh @@
// Assertion macros shared by the column strip matcher RTL.
`ifndef COLUMN_STRIP_SAD_MATCHER_DEFINES_SVH
`define COLUMN_STRIP_SAD_MATCHER_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define CSM_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define CSM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/csm_pkg.sv @@
// Shared constants, types and register codes of the column strip matcher.
`default_nettype none
package csm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int STRIP_HALF = 8;
    localparam int PIXEL_BITS = 8;

    localparam int STRIP_LEN   = 2 * STRIP_HALF;
    localparam int RING_ROWS   = STRIP_LEN - 1;
    localparam int SLOT_W      = $clog2(RING_ROWS);
    localparam int SLOTX_W     = SLOT_W + 1;
    localparam int STRIP_IDX_W = $clog2(STRIP_LEN);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 11;
    localparam int CMP_W       = 14;
    localparam int MATCH_W     = 11;
    localparam int SUM_OUT_W   = 12;
    localparam int SUM_MAX     = (1 << SUM_OUT_W) - 1;
    localparam int REF_IDX_W   = 4;
    localparam int PIX_IN_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int GROUPS  = (STRIP_LEN + 3) / 4;
    localparam int PART_W  = PIXEL_BITS + 2;
    localparam int SUM_W   = PART_W + $clog2(GROUPS);
    localparam int SUMX_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    localparam logic MODE_REF   = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    localparam logic [10:0] RST_IMAGE_WIDTH = 11'd1024;
    localparam logic [10:0] RST_FIRST_ROW   = 11'd24;
    localparam logic [10:0] RST_STOP_ROW    = 11'd1024;
    localparam logic [9:0]  RST_COL_START   = 10'd18;
    localparam logic [9:0]  RST_REF_ROW     = 10'd0;
    localparam logic [9:0]  RST_REF_COL     = 10'd0;
    localparam logic [11:0] RST_THRESHOLD   = 12'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_FIRST_ROW   = 3'd1,
        REG_STOP_ROW    = 3'd2,
        REG_COL_START   = 3'd3,
        REG_REF_ROW     = 3'd4,
        REG_REF_COL     = 3'd5,
        REG_THRESHOLD   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] first_row;
        logic [10:0] stop_row;
        logic [9:0]  col_start;
        logic [9:0]  ref_centre_row;
        logic [9:0]  ref_centre_col;
        logic [11:0] match_threshold;
    } t_cfg;

    typedef struct packed {
        logic                  is_pixel;
        logic [REF_IDX_W-1:0]  ref_idx;
        logic [PIXEL_BITS-1:0] pix;
        logic [COL_W-1:0]      col;
        logic [SLOT_W-1:0]     slot;
        logic                  cand;
        logic [MATCH_W-1:0]    mrow;
        logic [MATCH_W-1:0]    mcol;
    } t_item;

endpackage
`default_nettype wire

@@ sv/column_strip_sad_matcher.sv @@
// Top level of the column strip sum-of-absolute-differences matcher.
// The input channel (i_in_valid / o_in_ready) carries one word per cycle while the queue is not full:
// mode 0 words load one entry of the 16-pixel reference strip, mode 1 words
// are image pixels in raster order, with frame_start on the first pixel.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes one register per word and is
// always ready; the user must write it only while the block is idle; the block does not enforce this.
// The result channel (o_out_valid / i_out_ready) carries one word for each
// candidate centre whose sum falls below the threshold.
// Throughput is one input word per cycle while the receiver does not stall, set by the
// fifteen line-store RAMs that are all read and one written at the pixel's column per pixel.
// After its pixel is accepted, a result passes the queue and the s1, s2, s3 and output registers.
// When the receiver stalls, the result register holds and the pipeline
// freezes; the four-entry queue keeps taking words until it fills.
// Reset clears the raster counters, the queue and the pipeline valids and
// loads the register defaults; the strip and line store are not cleared.
`default_nettype none
module column_strip_sad_matcher
    import csm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_mode,
    input  wire logic [REF_IDX_W-1:0]  i_ref_index,
    input  wire logic [PIX_IN_W-1:0]   i_pixel_value,
    input  wire logic                  i_frame_start,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [MATCH_W-1:0]  o_match_row,
    output logic signed [MATCH_W-1:0]  o_match_col,
    output logic [SUM_OUT_W-1:0]       o_abs_diff_sum,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_full;
    logic  w_push;
    t_item w_front_item;
    logic  w_pop;
    logic  w_empty;
    t_item w_queue_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= RST_IMAGE_WIDTH;
            r_cfg.first_row       <= RST_FIRST_ROW;
            r_cfg.stop_row        <= RST_STOP_ROW;
            r_cfg.col_start       <= RST_COL_START;
            r_cfg.ref_centre_row  <= RST_REF_ROW;
            r_cfg.ref_centre_col  <= RST_REF_COL;
            r_cfg.match_threshold <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[10:0];
                end
                REG_FIRST_ROW: begin
                    r_cfg.first_row <= i_cfg_data[10:0];
                end
                REG_STOP_ROW: begin
                    r_cfg.stop_row <= i_cfg_data[10:0];
                end
                REG_COL_START: begin
                    r_cfg.col_start <= i_cfg_data[9:0];
                end
                REG_REF_ROW: begin
                    r_cfg.ref_centre_row <= i_cfg_data[9:0];
                end
                REG_REF_COL: begin
                    r_cfg.ref_centre_col <= i_cfg_data[9:0];
                end
                REG_THRESHOLD: begin
                    r_cfg.match_threshold <= i_cfg_data[11:0];
                end
                default: begin
                end
            endcase
        end
    end

    csm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_mode        (i_mode),
        .i_ref_index   (i_ref_index),
        .i_pixel_value (i_pixel_value),
        .i_frame_start (i_frame_start),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    csm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_empty (w_empty)
    );

    csm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_threshold    (r_cfg.match_threshold),
        .i_item         (w_queue_item),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_match_row    (o_match_row),
        .o_match_col    (o_match_col),
        .o_abs_diff_sum (o_abs_diff_sum)
    );

endmodule
`default_nettype wire

@@ sv/csm_ram.sv @@
// Generic single-port RAM with registered, read-before-write output.
`default_nettype none
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ sv/csm_front.sv @@
// Front end: accepts words, tracks raster position and classifies candidates.
`default_nettype none
module csm_front
    import csm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_mode,
    input  wire logic [REF_IDX_W-1:0]  i_ref_index,
    input  wire logic [PIX_IN_W-1:0]   i_pixel_value,
    input  wire logic                  i_frame_start,
    input  wire logic                  i_full,
    output logic                       o_push,
    output t_item                      o_item
);

    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic [CMP_W-1:0]  w_width;
    logic [COL_W-1:0]  w_col0;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic [SLOT_W-1:0] w_slot;
    logic              w_last;
    logic              w_cand;
    logic              w_is_pixel;

    assign o_ready    = !i_full;
    assign o_push     = i_valid && !i_full;
    assign w_is_pixel = (i_mode == MODE_PIXEL);

    always_comb begin
        if (i_cfg.image_width == '0) begin
            w_width = CMP_W'(1);
        end else if (CMP_W'(i_cfg.image_width) > CMP_W'(MAX_WIDTH)) begin
            w_width = CMP_W'(MAX_WIDTH);
        end else begin
            w_width = CMP_W'(i_cfg.image_width);
        end
    end

    always_comb begin
        w_col0 = i_frame_start ? '0 : r_col;
        w_row  = i_frame_start ? '0 : r_row;
        w_slot = i_frame_start ? '0 : r_slot;
        w_col  = (CMP_W'(w_col0) >= w_width) ? '0 : w_col0;
        w_last = (CMP_W'(w_col) + CMP_W'(1)) >= w_width;
        w_cand = (CMP_W'(w_row) >= CMP_W'(i_cfg.first_row) + CMP_W'(STRIP_HALF - 1))
              && (CMP_W'(w_row) >= CMP_W'(2 * STRIP_HALF))
              && (CMP_W'(w_row) + CMP_W'(1) < CMP_W'(i_cfg.stop_row))
              && (CMP_W'(w_col) >= CMP_W'(i_cfg.col_start));
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_slot = r_slot;
        if (o_push && w_is_pixel) begin
            if (w_last) begin
                n_col = '0;
                n_row = w_row + ROW_W'(1);
                if (w_row == '1) begin
                    n_slot = '0;
                end else if (w_slot == SLOT_W'(RING_ROWS - 1)) begin
                    n_slot = '0;
                end else begin
                    n_slot = w_slot + SLOT_W'(1);
                end
            end else begin
                n_col  = w_col + COL_W'(1);
                n_row  = w_row;
                n_slot = w_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    always_comb begin
        o_item.is_pixel = w_is_pixel;
        o_item.ref_idx  = i_ref_index;
        o_item.pix      = PIXEL_BITS'(i_pixel_value);
        o_item.col      = w_col;
        o_item.slot     = w_slot;
        o_item.cand     = w_cand;
        o_item.mrow     = MATCH_W'(w_row - ROW_W'(STRIP_HALF - 1)
                                   - ROW_W'(i_cfg.ref_centre_row));
        o_item.mcol     = MATCH_W'(w_col) - MATCH_W'(i_cfg.ref_centre_col);
    end

endmodule
`default_nettype wire

@@ sv/csm_queue.sv @@
// Short queue of classified words between the front and back ends.
`default_nettype none
`include "column_strip_sad_matcher_defines.svh"
module csm_queue
    import csm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_empty
);

    t_item           r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QA_W:0]   r_count;

    assign o_full  = (r_count == (QA_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QA_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QA_W + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QA_W + 1)'(1);
            end
        end
    end

    `CSM_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "queue pushed while full")
    `CSM_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "queue popped while empty")
    `CSM_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= (QA_W + 1)'(QUEUE_DEPTH), "queue count out of range")

endmodule
`default_nettype wire

@@ sv/csm_back.sv @@
// Back end: line store, reference strip and pipelined difference sum.
`default_nettype none
`include "column_strip_sad_matcher_defines.svh"
module csm_back
    import csm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [11:0]            i_threshold,
    input  wire t_item                  i_item,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic signed [MATCH_W-1:0]   o_match_row,
    output logic signed [MATCH_W-1:0]   o_match_col,
    output logic [SUM_OUT_W-1:0]        o_abs_diff_sum
);

    logic w_adv;
    logic w_pop;

    logic [PIXEL_BITS-1:0] w_ram_q [RING_ROWS];
    logic [PIXEL_BITS-1:0] r_ref   [STRIP_LEN];
    logic [PIXEL_BITS-1:0] w_tap   [STRIP_LEN];

    logic                  r_s1_valid;
    t_item                 r_s1_item;

    logic                  r_s2_valid;
    logic [PIXEL_BITS-1:0] r_s2_diff [STRIP_LEN];
    logic [MATCH_W-1:0]    r_s2_mrow;
    logic [MATCH_W-1:0]    r_s2_mcol;

    logic                  r_s3_valid;
    logic [PART_W-1:0]     w_part    [GROUPS];
    logic [PART_W-1:0]     r_s3_part [GROUPS];
    logic [MATCH_W-1:0]    r_s3_mrow;
    logic [MATCH_W-1:0]    r_s3_mcol;

    logic [SUM_W-1:0]      w_total;
    logic                  w_emit;
    logic [SUM_OUT_W-1:0]  w_sat;

    logic                  r_out_valid;
    logic [MATCH_W-1:0]    r_out_row;
    logic [MATCH_W-1:0]    r_out_col;
    logic [SUM_OUT_W-1:0]  r_out_sum;

    assign w_adv = !r_out_valid || i_ready;
    assign w_pop = w_adv && !i_empty;
    assign o_pop = w_pop;

    for (genvar gi = 0; gi < RING_ROWS; gi++) begin : g_ring
        csm_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_row (
            .i_clk   (i_clk),
            .i_we    (w_pop && i_item.is_pixel && (i_item.slot == SLOT_W'(gi))),
            .i_re    (w_pop && i_item.is_pixel),
            .i_addr  (i_item.col),
            .i_wdata (i_item.pix),
            .o_rdata (w_ram_q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= w_pop;
            r_s2_valid  <= r_s1_valid && r_s1_item.is_pixel && r_s1_item.cand;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_item <= i_item;
            if (r_s1_valid && !r_s1_item.is_pixel
                && (int'(r_s1_item.ref_idx) < STRIP_LEN)) begin
                r_ref[STRIP_IDX_W'(r_s1_item.ref_idx)] <= r_s1_item.pix;
            end
        end
    end

    always_comb begin
        logic [SLOTX_W-1:0] v_sel;
        v_sel = '0;
        for (int k = 0; k < STRIP_LEN; k++) begin
            if (k == STRIP_LEN - 1) begin
                w_tap[k] = r_s1_item.pix;
            end else begin
                v_sel = SLOTX_W'(r_s1_item.slot) + SLOTX_W'(k);
                if (v_sel >= SLOTX_W'(RING_ROWS)) begin
                    v_sel = v_sel - SLOTX_W'(RING_ROWS);
                end
                w_tap[k] = w_ram_q[v_sel[SLOT_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < STRIP_LEN; k++) begin
                r_s2_diff[k] <= (r_ref[k] > w_tap[k]) ? (r_ref[k] - w_tap[k])
                                                      : (w_tap[k] - r_ref[k]);
            end
            r_s2_mrow <= r_s1_item.mrow;
            r_s2_mcol <= r_s1_item.mcol;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_part[g] = '0;
            for (int j = 0; j < 4; j++) begin
                if (g * 4 + j < STRIP_LEN) begin
                    w_part[g] = w_part[g] + PART_W'(r_s2_diff[g * 4 + j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_part <= w_part;
            r_s3_mrow <= r_s2_mrow;
            r_s3_mcol <= r_s2_mcol;
        end
    end

    always_comb begin
        w_total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_total = w_total + SUM_W'(r_s3_part[g]);
        end
        w_emit = r_s3_valid && (SUMX_W'(w_total) < SUMX_W'(i_threshold));
        w_sat  = (SUMX_W'(w_total) > SUMX_W'(SUM_MAX)) ? SUM_OUT_W'(SUM_MAX)
                                                       : SUM_OUT_W'(w_total);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_row <= r_s3_mrow;
            r_out_col <= r_s3_mcol;
            r_out_sum <= w_sat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_match_row    = signed'(r_out_row);
    assign o_match_col    = signed'(r_out_col);
    assign o_abs_diff_sum = r_out_sum;

    `CSM_ASSERT_NEXT(a_stall_holds_sum, i_clk, i_rst_n, r_s3_valid && !w_adv, r_s3_valid, "summing stage lost a word during stall")
    `CSM_ASSERT_NOW(a_result_below_threshold, i_clk, i_rst_n, r_out_valid, r_out_sum < i_threshold, "result sum not below threshold")

endmodule
`default_nettype wire

@@ tb/tb_column_strip_sad_matcher.sv @@
// Randomized self-checking testbench for the column strip SAD matcher.
module tb_column_strip_sad_matcher;
    import csm_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_WORDS  = 700;
    localparam int TIMEOUT       = 2 * CLK_HALF * 1_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [MATCH_W-1:0]   row;
        logic [MATCH_W-1:0]   col;
        logic [SUM_OUT_W-1:0] sum;
    } t_sad_match;

    class sad_match_tracker;
        t_cfg                  cfg;
        logic [PIXEL_BITS-1:0] strip [STRIP_LEN];
        logic [PIXEL_BITS-1:0] lines [RING_ROWS*MAX_WIDTH];
        logic [ROW_W-1:0]      row_ctr;
        int unsigned           col_ctr;
        t_sad_match            pending_matches [$];
        int                    errors;

        function new();
            cfg.image_width     = RST_IMAGE_WIDTH;
            cfg.first_row       = RST_FIRST_ROW;
            cfg.stop_row        = RST_STOP_ROW;
            cfg.col_start       = RST_COL_START;
            cfg.ref_centre_row  = RST_REF_ROW;
            cfg.ref_centre_col  = RST_REF_COL;
            cfg.match_threshold = RST_THRESHOLD;
            row_ctr = '0;
            col_ctr = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_IMAGE_WIDTH: cfg.image_width     = d[10:0];
                REG_FIRST_ROW:   cfg.first_row       = d[10:0];
                REG_STOP_ROW:    cfg.stop_row        = d[10:0];
                REG_COL_START:   cfg.col_start       = d[9:0];
                REG_REF_ROW:     cfg.ref_centre_row  = d[9:0];
                REG_REF_COL:     cfg.ref_centre_col  = d[9:0];
                REG_THRESHOLD:   cfg.match_threshold = d[11:0];
                default: ;
            endcase
        endfunction

        function int unsigned line_width();
            if (cfg.image_width == 0) return 1;
            if (cfg.image_width > MAX_WIDTH) return MAX_WIDTH;
            return cfg.image_width;
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction

        function void take_word(logic m, logic [REF_IDX_W-1:0] idx,
                                logic [PIXEL_BITS-1:0] pix, logic fs);
            int unsigned w, r, c, k, v, ref_v, total;
            int lpos, stop, d;
            t_sad_match hit;
            if (m == MODE_REF) begin
                strip[idx] = pix;
                return;
            end
            w = line_width();
            if (fs) begin
                row_ctr = '0;
                col_ctr = 0;
            end
            if (col_ctr >= w) col_ctr = 0;
            r = row_ctr;
            c = col_ctr;
            lpos = int'(r) - STRIP_HALF + 1;
            stop = int'(cfg.stop_row);
            if (lpos >= int'(cfg.first_row) && lpos < stop && lpos > STRIP_HALF &&
                lpos < stop - STRIP_HALF && c >= cfg.col_start) begin
                total = 0;
                for (k = 0; k < STRIP_LEN; k++) begin
                    v = (k == STRIP_LEN - 1) ? pix : lines[((r + k) % RING_ROWS) * MAX_WIDTH + c];
                    ref_v = strip[k];
                    total += (ref_v > v) ? ref_v - v : v - ref_v;
                end
                if (total < cfg.match_threshold) begin
                    d = lpos - int'(cfg.ref_centre_row);
                    hit.row = d[MATCH_W-1:0];
                    d = int'(c) - int'(cfg.ref_centre_col);
                    hit.col = d[MATCH_W-1:0];
                    hit.sum = (total > SUM_MAX) ? SUM_MAX[SUM_OUT_W-1:0] : total[SUM_OUT_W-1:0];
                    pending_matches = {pending_matches, hit};
                end
            end
            lines[(r % RING_ROWS) * MAX_WIDTH + c] = pix;
            if (c + 1 >= w) begin
                col_ctr = 0;
                row_ctr = row_ctr + 1'b1;
            end else begin
                col_ctr = c + 1;
            end
        endfunction

        task report(string what);
            if (errors < 100) $display("mismatch: %s", what);
            errors++;
        endtask

        task check_match(logic [MATCH_W-1:0] row, logic [MATCH_W-1:0] col,
                         logic [SUM_OUT_W-1:0] sum);
            t_sad_match want;
            if (pending_matches.size() == 0) begin
                report($sformatf("match row %0d col %0d sum %0d with nothing expected",
                                 $signed(row), $signed(col), sum));
                return;
            end
            want = pending_matches.pop_front();
            if (row !== want.row)
                report($sformatf("match_row %0d, expected %0d", $signed(row), $signed(want.row)));
            if (col !== want.col)
                report($sformatf("match_col %0d, expected %0d", $signed(col), $signed(want.col)));
            if (sum !== want.sum)
                report($sformatf("abs_diff_sum %0d, expected %0d", sum, want.sum));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  i_mode        = MODE_REF;
    logic [REF_IDX_W-1:0]  i_ref_index   = '0;
    logic [PIX_IN_W-1:0]   i_pixel_value = '0;
    logic                  i_frame_start = 1'b0;
    logic                  i_out_ready   = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    logic signed [MATCH_W-1:0] o_match_row;
    logic signed [MATCH_W-1:0] o_match_col;
    logic [SUM_OUT_W-1:0]  o_abs_diff_sum;

    sad_match_tracker tracker;
    int   words_sent    = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_ask      = 1'b0;

    column_strip_sad_matcher DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_ref_index    (i_ref_index),
        .i_pixel_value  (i_pixel_value),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_match_row    (o_match_row),
        .o_match_col    (o_match_col),
        .o_abs_diff_sum (o_abs_diff_sum),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    task automatic send_word(input logic m, input logic [REF_IDX_W-1:0] idx,
                             input logic [PIX_IN_W-1:0] pix, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= m;
        i_ref_index   <= idx;
        i_pixel_value <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_word(m, idx, pix, fs);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input int w, input int fr, input int sr, input int cs,
                                input int rr, input int rc, input int th);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_DATA_W-1:0] keep [8];
        logic [CFG_DATA_W-1:0] junk;
        int i;
        vals = '{CFG_DATA_W'(w), CFG_DATA_W'(fr), CFG_DATA_W'(sr), CFG_DATA_W'(cs),
                 CFG_DATA_W'(rr), CFG_DATA_W'(rc), CFG_DATA_W'(th), CFG_DATA_W'($urandom)};
        keep = '{12'h7FF, 12'h7FF, 12'h7FF, 12'h3FF, 12'h3FF, 12'h3FF, 12'hFFF, 12'hFFF};
        for (i = 0; i <= int'(REG_SPARE); i++) begin
            junk = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom) & ~keep[i] : '0;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= (vals[i] & keep[i]) | junk;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.write_reg(i_cfg_index, i_cfg_data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_frame(input int w, input int fr, input int sr, input int cs,
                             input int rr, input int rc, input int th, input int count,
                             input logic [PIX_IN_W-1:0] noise, input int fs_permille,
                             input int ref_pct, input int pause_at, input bit hold);
        int j, row;
        logic fs;
        logic [PIX_IN_W-1:0] pix;
        drain();
        program_regs(w, fr, sr, cs, rr, rc, th);
        if (hold) hold_ask <= ~hold_ask;
        for (j = 0; j < count; j++) begin
            if (j == pause_at) drain();
            if (j > 0 && $urandom_range(99) < ref_pct) begin
                send_word(MODE_REF, REF_IDX_W'($urandom), PIX_IN_W'($urandom), 1'($urandom));
            end else begin
                fs = (j == 0) || ($urandom_range(999) < fs_permille);
                row = fs ? 0 : int'(tracker.row_ctr);
                pix = tracker.strip[(row + STRIP_HALF) % STRIP_LEN] ^ (PIX_IN_W'($urandom) & noise);
                send_word(MODE_PIXEL, REF_IDX_W'($urandom), pix, fs);
            end
        end
    endtask

    function automatic int pick_value(int lo, int hi, int typ_lo, int typ_hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return $urandom_range(hi, lo);
            default: return $urandom_range(typ_hi, typ_lo);
        endcase
    endfunction

    initial begin : result_sink
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready)
                tracker.check_match(o_match_row, o_match_col, o_abs_diff_sum);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : stimulus
        int i, frame_no, w, eff;
        logic [PIX_IN_W-1:0] noise;
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 22;
        recv_idle_pct <= 57;

        program_regs(0, 0, 2047, 0, 1023, 1023, 4095);
        for (i = 0; i < STRIP_LEN; i++)
            send_word(MODE_REF, REF_IDX_W'(i),
                      (i == 0) ? 8'h00 : (i == STRIP_LEN - 1) ? 8'hFF : PIX_IN_W'($urandom),
                      i[0]);
        for (i = 0; i < 19; i++)
            send_word(MODE_PIXEL, REF_IDX_W'($urandom), i[0] ? 8'hFF : 8'h00, i == 0);

        frame_no = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent < RANDOM_WORDS / 3) begin
                send_idle_pct = 22;
                recv_idle_pct <= 57;
            end else if (words_sent < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 57;
                recv_idle_pct <= 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (frame_no == 1) begin
                run_frame(1, 0, 2047, 0, $urandom_range(1023), $urandom_range(1023), 4095,
                          120, 8'h0F, 0, 0, 60, 1'b1);
            end else begin
                w = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
                eff = (w == 0) ? 1 : w;
                case ($urandom_range(3))
                    0: noise = 8'h00;
                    1: noise = 8'h03;
                    2: noise = 8'h0F;
                    default: noise = 8'hFF;
                endcase
                run_frame(w, pick_value(0, 2047, 0, 30), pick_value(0, 2047, 20, 60),
                          pick_value(0, 1023, 0, eff - 1), pick_value(0, 1023, 0, 1023),
                          pick_value(0, 1023, 0, 1023), pick_value(0, 4095, 100, 1500),
                          eff * $urandom_range(40, 17), noise, 4, 3, -1, 1'b0);
            end
            frame_no++;
        end

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_frame(2047, 9, 30, 1000, 0, 0, 4095, 64, 8'h0F, 0, 0, -1, 1'b0);

        drain();
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("simulation failed");
        $finish;
    end

endmodule
